@@ design/gfbl_pkg.sv @@
package gfbl_pkg;

    localparam int BLK_W   = 10;
    localparam int TDATA_W = 16;

    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef enum logic [1:0] {
        RES_NONE,
        RES_FAIL,
        RES_BLOCK
    } t_res_sel;

    typedef struct packed {
        logic     capture;
        logic     sweep_start;
        logic     spill;
        logic     sweep_step;
        logic     sweeping;
        logic     pop;
        logic     push;
        logic     seed;
        logic     set_link;
        logic     set_full;
        logic     res_load;
        t_res_sel res_sel;
        logic     emit;
    } t_dp_cmd;

    typedef struct packed {
        logic req_release;
        logic count_zero;
        logic count_one;
        logic count_full;
        logic blk_oob;
        logic link_bad;
        logic sweep_last;
        logic out_free;
    } t_dp_sts;

endpackage

@@ design/grouped_free_block_list_top.sv @@
// Channel   Dir  Beat fields
// s_axis    in   tdata[9:0] block_number, tuser[0] req_type (0 alloc, 1 release)
// m_axis    out  tdata[9:0] allocated_block, tuser[0] status (0 ok, 1 no block)
//
// One request at a time. A pop, a push or any failed or ignored request passes
// the decide and finish states; a release into an empty stack adds a seed state.
// A refill or a spill stays in a sweep state for the group copy that
// moves one entry a cycle between the free-stack RAM and the group store.
// Reset clears the count and the control state; neither memory is cleared.
// A stalled result sits in the output register; the next request is taken
// meanwhile and waits for that register before it issues its own result.
module grouped_free_block_list_top #(
    parameter int GROUP_SIZE = 100,
    parameter int NUM_BLOCKS = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [gfbl_pkg::TDATA_W-1:0] i_s_axis_tdata,  // [9:0] block_number
    input  logic [0:0]                   i_s_axis_tuser,  // [0] req_type
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    output logic [gfbl_pkg::TDATA_W-1:0] o_m_axis_tdata,  // [9:0] allocated_block
    output logic [0:0]                   o_m_axis_tuser   // [0] status
);

    import gfbl_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_ready;
    logic    w_accept;

    assign w_accept        = i_s_axis_tvalid && w_ready;
    assign o_s_axis_tready = w_ready;

    gfbl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_sts    (w_sts),
        .o_cmd    (w_cmd),
        .o_ready  (w_ready)
    );

    gfbl_dp #(
        .GROUP_SIZE (GROUP_SIZE),
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_s_tdata  (i_s_axis_tdata),
        .i_s_tuser  (i_s_axis_tuser),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_m_tdata  (o_m_axis_tdata),
        .o_m_tuser  (o_m_axis_tuser)
    );

endmodule

@@ design/gfbl_ram.sv @@
module gfbl_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 100
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/gfbl_ctrl.sv @@
module gfbl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  gfbl_pkg::t_dp_sts i_sts,
    output gfbl_pkg::t_dp_cmd o_cmd,
    output logic              o_ready
);

    import gfbl_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SEED,
        ST_SWEEP,
        ST_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_ready, n_ready;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_ready = r_ready;
        unique case (r_state)
            ST_IDLE: begin
                if (i_accept) begin
                    o_cmd.capture = 1'b1;
                    n_ready       = 1'b0;
                    n_state       = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                o_cmd.res_load = 1'b1;
                n_state        = ST_FINISH;
                if (!i_sts.req_release) begin
                    if (i_sts.count_zero) begin
                        o_cmd.res_sel = RES_FAIL;
                    end else if (i_sts.count_one) begin
                        if (i_sts.link_bad) begin
                            o_cmd.res_sel = RES_FAIL;
                        end else begin
                            o_cmd.res_sel     = RES_BLOCK;
                            o_cmd.sweep_start = 1'b1;
                            o_cmd.spill       = 1'b0;
                            n_state           = ST_SWEEP;
                        end
                    end else begin
                        o_cmd.res_sel = RES_BLOCK;
                        o_cmd.pop     = 1'b1;
                    end
                end else begin
                    o_cmd.res_sel = RES_NONE;
                    if (!i_sts.blk_oob) begin
                        if (i_sts.count_full) begin
                            o_cmd.sweep_start = 1'b1;
                            o_cmd.spill       = 1'b1;
                            n_state           = ST_SWEEP;
                        end else if (i_sts.count_zero) begin
                            o_cmd.seed = 1'b1;
                            n_state    = ST_SEED;
                        end else begin
                            o_cmd.push = 1'b1;
                        end
                    end
                end
            end
            ST_SEED: begin
                o_cmd.push = 1'b1;
                n_state    = ST_FINISH;
            end
            ST_SWEEP: begin
                o_cmd.sweeping = 1'b1;
                if (i_sts.sweep_last) begin
                    o_cmd.set_link = i_sts.req_release;
                    o_cmd.set_full = !i_sts.req_release;
                    n_state        = ST_FINISH;
                end else begin
                    o_cmd.sweep_step = 1'b1;
                end
            end
            ST_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_ready    = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_ready = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= (r_state == ST_IDLE && !i_accept) ? 1'b1 : n_ready;
        end
    end

    assign o_ready = r_ready;

endmodule

@@ design/gfbl_dp.sv @@
module gfbl_dp #(
    parameter int GROUP_SIZE = 100,
    parameter int NUM_BLOCKS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gfbl_pkg::t_dp_cmd             i_cmd,
    output gfbl_pkg::t_dp_sts             o_sts,
    input  logic [gfbl_pkg::TDATA_W-1:0]  i_s_tdata,
    input  logic [0:0]                    i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [gfbl_pkg::TDATA_W-1:0]  o_m_tdata,
    output logic [0:0]                    o_m_tuser
);

    import gfbl_pkg::*;

    localparam int MAX_BLOCKS = 1 << BLK_W;
    localparam int EFF_BLOCKS = (NUM_BLOCKS < MAX_BLOCKS) ? NUM_BLOCKS : MAX_BLOCKS;
    localparam int GS_DEPTH   = EFF_BLOCKS * GROUP_SIZE;
    localparam int GAW        = $clog2(GS_DEPTH);
    localparam int AW         = $clog2(GROUP_SIZE);
    localparam int IW         = $clog2(GROUP_SIZE + 1);

    logic             r_req;
    logic [BLK_W-1:0] r_blk;
    logic [IW-1:0]    r_count;
    logic [IW-1:0]    r_idx;
    logic             r_spill;
    logic [GAW-1:0]   r_base;
    logic             r_res_status;
    logic [BLK_W-1:0] r_res_blk;
    logic             r_out_valid;
    logic             r_out_status;
    logic [BLK_W-1:0] r_out_blk;

    logic [BLK_W-1:0] w_fs_rdata;
    logic [BLK_W-1:0] w_gs_rdata;
    logic             w_fs_we;
    logic [AW-1:0]    w_fs_waddr;
    logic [BLK_W-1:0] w_fs_wdata;
    logic [AW-1:0]    w_fs_raddr;
    logic             w_gs_we;
    logic             w_gs_re;
    logic [GAW-1:0]   w_gs_waddr;
    logic [GAW-1:0]   w_gs_raddr;
    logic [IW-1:0]    w_idx_m1;
    logic [IW-1:0]    w_count_m1;
    logic [BLK_W-1:0] w_base_src;
    logic [GAW-1:0]   n_base;
    logic             w_idx_nz;

    assign w_idx_m1   = r_idx - IW'(1);
    assign w_count_m1 = r_count - IW'(1);
    assign w_idx_nz   = (r_idx != '0);
    assign w_base_src = i_cmd.spill ? r_blk : w_fs_rdata;
    assign n_base     = GAW'(w_base_src) * GAW'(GROUP_SIZE);

    assign w_fs_raddr = (i_cmd.sweeping && r_spill) ? r_idx[AW-1:0] : w_count_m1[AW-1:0];
    assign w_gs_re    = i_cmd.sweeping && !r_spill && (32'(r_idx) < GROUP_SIZE);
    assign w_gs_raddr = r_base + GAW'(r_idx);
    assign w_gs_we    = i_cmd.sweeping && r_spill && w_idx_nz;
    assign w_gs_waddr = r_base + GAW'(w_idx_m1);

    always_comb begin
        w_fs_we    = 1'b0;
        w_fs_waddr = '0;
        w_fs_wdata = '0;
        if (i_cmd.sweeping && !r_spill && w_idx_nz) begin
            w_fs_we    = 1'b1;
            w_fs_waddr = w_idx_m1[AW-1:0];
            w_fs_wdata = w_gs_rdata;
        end else if (i_cmd.push) begin
            w_fs_we    = 1'b1;
            w_fs_waddr = r_count[AW-1:0];
            w_fs_wdata = r_blk;
        end else if (i_cmd.seed) begin
            w_fs_we    = 1'b1;
            w_fs_waddr = '0;
            w_fs_wdata = '0;
        end else if (i_cmd.set_link) begin
            w_fs_we    = 1'b1;
            w_fs_waddr = '0;
            w_fs_wdata = r_blk;
        end
    end

    gfbl_ram #(
        .WIDTH (BLK_W),
        .DEPTH (GROUP_SIZE)
    ) u_free_stack (
        .i_clk   (i_clk),
        .i_we    (w_fs_we),
        .i_waddr (w_fs_waddr),
        .i_wdata (w_fs_wdata),
        .i_re    (1'b1),
        .i_raddr (w_fs_raddr),
        .o_rdata (w_fs_rdata)
    );

    gfbl_ram #(
        .WIDTH (BLK_W),
        .DEPTH (GS_DEPTH)
    ) u_group_store (
        .i_clk   (i_clk),
        .i_we    (w_gs_we),
        .i_waddr (w_gs_waddr),
        .i_wdata (w_fs_rdata),
        .i_re    (w_gs_re),
        .i_raddr (w_gs_raddr),
        .o_rdata (w_gs_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_s_tuser[0];
            r_blk <= i_s_tdata[BLK_W-1:0];
        end
        if (i_cmd.sweep_start) begin
            r_spill <= i_cmd.spill;
            r_base  <= n_base;
            r_idx   <= '0;
        end else if (i_cmd.sweep_step) begin
            r_idx <= r_idx + IW'(1);
        end
        if (i_cmd.res_load) begin
            unique case (i_cmd.res_sel)
                RES_FAIL: begin
                    r_res_status <= STATUS_FAIL;
                    r_res_blk    <= '0;
                end
                RES_BLOCK: begin
                    r_res_status <= STATUS_OK;
                    r_res_blk    <= w_fs_rdata;
                end
                default: begin
                    r_res_status <= STATUS_OK;
                    r_res_blk    <= '0;
                end
            endcase
        end
        if (i_cmd.emit) begin
            r_out_status <= r_res_status;
            r_out_blk    <= r_res_blk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.pop) begin
                r_count <= w_count_m1;
            end else if (i_cmd.push) begin
                r_count <= r_count + IW'(1);
            end else if (i_cmd.seed || i_cmd.set_link) begin
                r_count <= IW'(1);
            end else if (i_cmd.set_full) begin
                r_count <= IW'(GROUP_SIZE);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts             = '0;
        o_sts.req_release = (r_req == REQ_RELEASE);
        o_sts.count_zero  = (r_count == '0);
        o_sts.count_one   = (r_count == IW'(1));
        o_sts.count_full  = (32'(r_count) >= GROUP_SIZE);
        o_sts.blk_oob     = (32'(r_blk) >= NUM_BLOCKS);
        o_sts.link_bad    = (w_fs_rdata == '0) || (32'(w_fs_rdata) >= NUM_BLOCKS);
        o_sts.sweep_last  = (32'(r_idx) == GROUP_SIZE);
        o_sts.out_free    = !r_out_valid || i_m_tready;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = TDATA_W'(r_out_blk);
    assign o_m_tuser  = r_out_status;

endmodule

@@ design/gfbl_checker.sv @@
module gfbl_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_s_axis_tvalid,
    input logic                         o_s_axis_tready,
    input logic                         o_m_axis_tvalid,
    input logic                         i_m_axis_tready,
    input logic [gfbl_pkg::TDATA_W-1:0] o_m_axis_tdata,
    input logic [0:0]                   o_m_axis_tuser
);

    import gfbl_pkg::*;

    // one request in flight: no accept on the cycle after an accept
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input accepted while a request is in flight");

    // a failed allocate hands out block zero
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0] == STATUS_FAIL) |-> (o_m_axis_tdata == '0))
        else $error("failed allocate carries a block number");

    // a result needs an accepted request: none right after reset
    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result beat right after reset");

    // hold a stalled result beat
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid)
        else $error("result beat dropped while stalled");

endmodule

bind grouped_free_block_list_top gfbl_checker u_gfbl_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
